// File: hdl/kdm_pkg.sv
package kdm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] NO_KEY   = 5'd16;
    localparam logic [4:0] CTRL_KEY = 5'd12;

    localparam logic OP_SCAN   = 1'b0;
    localparam logic OP_TOGGLE = 1'b1;

    localparam logic [7:0]  DEBOUNCE_RESET    = 8'd3;
    localparam logic [15:0] LONG_PRESS_RESET  = 16'd800;
    localparam logic [15:0] TAP_TIMEOUT_RESET = 16'd1500;

    typedef enum logic [1:0] {
        REG_DEBOUNCE,
        REG_LONG_PRESS,
        REG_TAP_TIMEOUT
    } kdm_reg_t;

    typedef struct packed {
        logic        op;
        logic [15:0] pressed_mask;
        logic [31:0] now_ms;
    } kdm_item_t;

    typedef struct packed {
        logic [4:0] stable_key;
        logic       key_held;
        logic       release_pulse;
        logic [4:0] released_code;
        logic       long_hold;
        logic       ctrl_down;
        logic       caps_on;
        logic [4:0] tap_key;
        logic [4:0] tap_position;
        logic [6:0] tap_char;
    } kdm_result_t;

    // classified scan beat passed from front to back
    typedef struct packed {
        logic        op;
        logic [4:0]  raw_key;
        logic [31:0] now_ms;
    } kdm_scan_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } kdm_cfg_t;

    typedef struct packed {
        logic fire;
        logic out_ready;
    } kdm_back_status_t;

    localparam logic [7:0] TBL_K1 [0:23] = '{
        8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h27, 8'h22, 8'h3B, 8'h3A,
        8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h3D, 8'h40, 8'h23, 8'h24,
        8'h25, 8'h26, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3C, 8'h3E
    };

    function automatic logic [4:0] tap_len(input logic [4:0] key);
        logic [4:0] len;
        unique case (key)
            5'd0:                         len = 5'd24;
            5'd1, 5'd2, 5'd4, 5'd5, 5'd6: len = 5'd4;
            5'd9:                         len = 5'd4;
            5'd8, 5'd10:                  len = 5'd5;
            5'd13:                        len = 5'd3;
            default:                      len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [6:0] tap_char(input logic [4:0] key, input logic [4:0] idx,
                                            input logic caps);
        logic [4:0] len;
        logic [4:0] i;
        logic [7:0] base;
        logic [7:0] digit;
        logic [7:0] ch;
        len = tap_len(key);
        i = (idx >= len) ? 5'd0 : idx;
        base = 8'h00;
        digit = 8'h00;
        unique case (key)
            5'd1:    begin base = 8'h61; digit = 8'h32; end
            5'd2:    begin base = 8'h64; digit = 8'h33; end
            5'd4:    begin base = 8'h67; digit = 8'h34; end
            5'd5:    begin base = 8'h6A; digit = 8'h35; end
            5'd6:    begin base = 8'h6D; digit = 8'h36; end
            5'd8:    begin base = 8'h70; digit = 8'h37; end
            5'd9:    begin base = 8'h74; digit = 8'h38; end
            5'd10:   begin base = 8'h77; digit = 8'h39; end
            default: begin base = 8'h00; digit = 8'h00; end
        endcase
        if (len == 5'd0) begin
            ch = 8'h00;
        end else if (key == 5'd0) begin
            ch = TBL_K1[i];
        end else if (key == 5'd13) begin
            unique case (i)
                5'd0:    ch = 8'h20;
                5'd1:    ch = 8'h5F;
                default: ch = 8'h30;
            endcase
        end else if (i == len - 5'd1) begin
            ch = digit;
        end else begin
            ch = base + {3'b000, i};
        end
        // uppercase letters under caps lock
        if (caps && ch >= 8'h61 && ch <= 8'h7A) begin
            ch = ch - 8'h20;
        end
        return ch[6:0];
    endfunction

endpackage

// File: hdl/kdm_fifo.sv
module kdm_fifo #(
    parameter int  DEPTH  = kdm_pkg::QUEUE_DEPTH,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr,
    output logic  full,
    input  logic  pop,
    output item_t rd,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr;
        end
    end

endmodule

// File: hdl/kdm_front.sv
module kdm_front #(
    parameter int DEPTH = kdm_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kdm_pkg::kdm_item_t item,
    output logic               full,
    input  logic               scan_pop,
    output kdm_pkg::kdm_scan_t scan,
    output logic               scan_empty
);

    kdm_pkg::kdm_scan_t classified;
    logic [4:0]         raw_key;

    // highest pressed position wins
    always_comb
    begin
        raw_key = kdm_pkg::NO_KEY;
        for (int b = 0; b < 16; b++)
        begin
            if (item.pressed_mask[b])
            begin
                raw_key = 5'(b);
            end
        end
    end

    always_comb
    begin
        classified.op      = item.op;
        classified.raw_key = raw_key;
        classified.now_ms  = item.now_ms;
    end

    kdm_fifo #(
        .DEPTH  (DEPTH),
        .item_t (kdm_pkg::kdm_scan_t)
    ) u_scan_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wr    (classified),
        .full  (full),
        .pop   (scan_pop),
        .rd    (scan),
        .empty (scan_empty)
    );

endmodule

// File: hdl/kdm_back.sv
module kdm_back #(
    parameter int DEPTH = kdm_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kdm_pkg::kdm_cfg_t         cfg,
    input  kdm_pkg::kdm_scan_t        scan,
    input  logic                      scan_empty,
    output kdm_pkg::kdm_back_status_t status,
    output kdm_pkg::kdm_result_t      result,
    output logic                      empty,
    input  logic                      pop
);

    logic [7:0]  debounce_reg;
    logic [15:0] long_press_reg;
    logic [15:0] tap_timeout_reg;

    logic [4:0]  held_key_reg,     held_key_next;
    logic [7:0]  change_count_reg, change_count_next;
    logic        down_reg,         down_next;
    logic        release_reg,      release_next;
    logic [4:0]  release_code_reg, release_code_next;
    logic        long_reg,         long_next;
    logic [31:0] press_stamp_reg,  press_stamp_next;
    logic [4:0]  tap_key_reg,      tap_key_next;
    logic [31:0] tap_stamp_reg,    tap_stamp_next;
    logic [4:0]  tap_index_reg,    tap_index_next;
    logic        ctrl_reg,         ctrl_next;
    logic        caps_reg,         caps_next;

    logic                 out_full;
    logic                 fire;
    logic [7:0]           count_inc;
    logic [7:0]           need;
    logic [31:0]          held_time;
    logic [31:0]          tap_gap;
    logic [4:0]           raw_len;
    logic [4:0]           index_inc;
    kdm_pkg::kdm_result_t beat;

    assign fire             = !scan_empty && !out_full;
    assign status.fire      = fire;
    assign status.out_ready = !out_full;

    assign count_inc = change_count_reg + 8'd1;
    assign need      = (debounce_reg == 8'd0) ? 8'd1 : debounce_reg;
    assign held_time = scan.now_ms - press_stamp_reg;
    assign tap_gap   = scan.now_ms - tap_stamp_reg;
    assign raw_len   = kdm_pkg::tap_len(scan.raw_key);
    assign index_inc = tap_index_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= kdm_pkg::DEBOUNCE_RESET;
            long_press_reg  <= kdm_pkg::LONG_PRESS_RESET;
            tap_timeout_reg <= kdm_pkg::TAP_TIMEOUT_RESET;
        end else if (cfg.we)
        begin
            unique case (cfg.index)
                kdm_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg.data[7:0];
                kdm_pkg::REG_LONG_PRESS:  long_press_reg  <= cfg.data;
                kdm_pkg::REG_TAP_TIMEOUT: tap_timeout_reg <= cfg.data;
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        held_key_next     = held_key_reg;
        change_count_next = change_count_reg;
        down_next         = down_reg;
        release_next      = release_reg;
        release_code_next = release_code_reg;
        long_next         = long_reg;
        press_stamp_next  = press_stamp_reg;
        tap_key_next      = tap_key_reg;
        tap_stamp_next    = tap_stamp_reg;
        tap_index_next    = tap_index_reg;
        ctrl_next         = ctrl_reg;
        caps_next         = caps_reg;

        if (scan.op == kdm_pkg::OP_TOGGLE)
        begin
            caps_next = !caps_reg;
        end else
        begin
            release_next      = 1'b0;
            release_code_next = kdm_pkg::NO_KEY;
            if (scan.raw_key != held_key_reg)
            begin
                change_count_next = count_inc;
                if (count_inc >= need)
                begin
                    if (scan.raw_key == kdm_pkg::NO_KEY)
                    begin
                        release_next      = 1'b1;
                        release_code_next = held_key_reg;
                        long_next         = held_time >= {16'd0, long_press_reg};
                    end else
                    begin
                        press_stamp_next = scan.now_ms;
                        long_next        = 1'b0;
                        if (raw_len != 5'd0)
                        begin
                            // same key inside the timeout advances, anything else restarts
                            if (scan.raw_key == tap_key_reg && tap_gap < {16'd0, tap_timeout_reg})
                            begin
                                tap_index_next = (index_inc >= raw_len) ? 5'd0 : index_inc;
                            end else
                            begin
                                tap_index_next = 5'd0;
                            end
                            tap_key_next   = scan.raw_key;
                            tap_stamp_next = scan.now_ms;
                        end
                    end
                    if (scan.raw_key == kdm_pkg::CTRL_KEY)
                    begin
                        ctrl_next = 1'b1;
                    end else if (held_key_reg == kdm_pkg::CTRL_KEY
                                 && scan.raw_key == kdm_pkg::NO_KEY)
                    begin
                        ctrl_next = 1'b0;
                        if (!long_next)
                        begin
                            caps_next = !caps_reg;
                        end
                    end
                    held_key_next     = scan.raw_key;
                    down_next         = scan.raw_key != kdm_pkg::NO_KEY;
                    change_count_next = 8'd0;
                end
            end else
            begin
                change_count_next = 8'd0;
                if (held_key_reg != kdm_pkg::NO_KEY && !long_reg
                    && held_time >= {16'd0, long_press_reg})
                begin
                    long_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key_reg     <= kdm_pkg::NO_KEY;
            change_count_reg <= 8'd0;
            down_reg         <= 1'b0;
            release_reg      <= 1'b0;
            release_code_reg <= kdm_pkg::NO_KEY;
            long_reg         <= 1'b0;
            press_stamp_reg  <= 32'd0;
            tap_key_reg      <= kdm_pkg::NO_KEY;
            tap_stamp_reg    <= 32'd0;
            tap_index_reg    <= 5'd0;
            ctrl_reg         <= 1'b0;
            caps_reg         <= 1'b0;
        end else if (fire)
        begin
            held_key_reg     <= held_key_next;
            change_count_reg <= change_count_next;
            down_reg         <= down_next;
            release_reg      <= release_next;
            release_code_reg <= release_code_next;
            long_reg         <= long_next;
            press_stamp_reg  <= press_stamp_next;
            tap_key_reg      <= tap_key_next;
            tap_stamp_reg    <= tap_stamp_next;
            tap_index_reg    <= tap_index_next;
            ctrl_reg         <= ctrl_next;
            caps_reg         <= caps_next;
        end
    end

    always_comb
    begin
        beat.stable_key    = held_key_next;
        beat.key_held      = down_next;
        beat.release_pulse = release_next;
        beat.released_code = release_code_next;
        beat.long_hold     = long_next;
        beat.ctrl_down     = ctrl_next;
        beat.caps_on       = caps_next;
        beat.tap_key       = tap_key_next;
        beat.tap_position  = tap_index_next;
        beat.tap_char      = kdm_pkg::tap_char(tap_key_next, tap_index_next, caps_next);
    end

    kdm_fifo #(
        .DEPTH  (DEPTH),
        .item_t (kdm_pkg::kdm_result_t)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .wr    (beat),
        .full  (out_full),
        .pop   (pop),
        .rd    (result),
        .empty (empty)
    );

endmodule

// File: hdl/keypad_debounce_multitap_unit.sv
// Keypad debounce, long press and multi-tap unit for a 4x4 key matrix.
// Input side is a queue: drive item and raise push; the beat is taken on a
// clock edge where push is high and full is low. Each beat is either a scan
// sample (mask of pressed positions plus a millisecond tick) or a caps lock
// toggle. Result side is a queue too: while empty is low the oldest result
// sits on result, and a clock edge with pop high takes it. Every input beat
// gives exactly one result beat, in order.
// A taken beat goes into the scan queue; the state update reads it there and
// writes its result into the result queue. The short scan queue sustains one
// beat per cycle, and the state update takes one beat a cycle, while the
// result queue is not full. If the result side is not popped, the result
// queue fills, the update stalls, the input queue fills and full rises;
// nothing is dropped.
// Configuration: wr_en, wr_index and wr_data write one register in a cycle;
// write only while no beat is in flight. Indexes beyond the list are ignored.
// Reset clears both queues and all key state and restores register defaults.
module keypad_debounce_multitap_unit #(
    parameter int QUEUE_DEPTH = kdm_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kdm_pkg::kdm_item_t   item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output kdm_pkg::kdm_result_t result,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [15:0]          wr_data
);

    kdm_pkg::kdm_scan_t        scan;
    logic                      scan_empty;
    kdm_pkg::kdm_cfg_t         cfg;
    kdm_pkg::kdm_back_status_t status;

    always_comb
    begin
        cfg.we    = wr_en;
        cfg.index = wr_index;
        cfg.data  = wr_data;
    end

    kdm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .scan_pop   (status.fire),
        .scan       (scan),
        .scan_empty (scan_empty)
    );

    kdm_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .scan       (scan),
        .scan_empty (scan_empty),
        .status     (status),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTH
    // an update always leaves a result waiting
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        status.fire |=> !empty)
        else $error("update fired but no result queued");

    // an accepted beat is held in the scan queue
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !scan_empty)
        else $error("accepted beat missing from scan queue");

    // the update never runs ahead of the result side
    a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        status.fire |-> (status.out_ready && !scan_empty))
        else $error("update fired without room or input");

    // full input side means work is waiting
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !scan_empty)
        else $error("input full with empty scan queue");
`endif

endmodule
